[design/tape_machine_step_engine_macros.svh]
// Assertion macros for the tape machine step engine.
`ifndef TAPE_MACHINE_STEP_ENGINE_MACROS_SVH
`define TAPE_MACHINE_STEP_ENGINE_MACROS_SVH

`ifndef SYNTHESIS
`define TMSE_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tape machine step engine check failed");
`define TMSE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tape machine step engine check failed");
`else
`define TMSE_ASSERT_IMPLIES(label, ante, cons)
`define TMSE_ASSERT_NEXT(label, ante, cons)
`endif

`endif

[design/tmse_pkg.sv]
// Shared types, codes and constants of the tape machine step engine.
`default_nettype none

package tmse_pkg;

  localparam int MAX_STATES_DEF  = 64;
  localparam int TAPE_DEPTH_DEF  = 4096;
  localparam int SYMBOL_BITS_DEF = 8;

  localparam int PADDR_W = 5;
  localparam int PDATA_W = 64;
  localparam int STATE_W = 6;
  localparam int SYM_W   = 8;
  localparam int COUNT_W = 7;

  localparam logic [COUNT_W-1:0] STATE_COUNT_RST = 7'd1;
  localparam logic [STATE_W-1:0] START_STATE_RST = 6'd0;
  localparam logic [SYM_W-1:0]   BLANK_RST       = 8'd32;
  localparam logic [63:0]        FINAL_MASK_RST  = 64'd1;

  typedef enum logic [1:0] {
    REG_STATE_COUNT  = 2'd0,
    REG_START_STATE  = 2'd1,
    REG_BLANK_SYMBOL = 2'd2,
    REG_FINAL_MASK   = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    OP_DEFINE = 2'd0,
    OP_START  = 2'd1,
    OP_APPEND = 2'd2,
    OP_STEP   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_RANGE    = 3'd1,
    ST_DUP      = 3'd2,
    ST_OVERFLOW = 3'd3,
    ST_HALTED   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    MV_LEFT  = 2'd0,
    MV_RIGHT = 2'd1,
    MV_STAY  = 2'd2
  } move_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DEF_RD,
    S_DEF_WR,
    S_START,
    S_APPEND,
    S_TAPE_RD,
    S_RULE_RD,
    S_EVAL,
    S_GROW
  } ctrl_state_t;

  typedef struct packed {
    logic clr_step;
    logic take;
    logic def_rd;
    logic def_wr;
    logic start;
    logic append;
    logic tape_rd;
    logic rule_rd;
    logic apply;
    logic grow;
    logic finish;
    logic post;
  } tmse_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic rule_hit;
    logic grow_need;
    logic grow_ovf;
    logic out_free;
  } tmse_sts_t;

endpackage

`default_nettype wire

[design/tmse_regs.sv]
// Configuration register file behind the APB-style port.
`default_nettype none

module tmse_regs import tmse_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [PADDR_W-1:0]   paddr,
  input  wire logic [PDATA_W-1:0]   pwdata,
  output logic      [PDATA_W-1:0]   prdata,
  output logic                      pready,
  output logic      [COUNT_W-1:0]   state_count,
  output logic      [STATE_W-1:0]   start_state,
  output logic      [SYM_W-1:0]     blank_symbol,
  output logic      [63:0]          final_mask
);

  logic [COUNT_W-1:0] state_count_r;
  logic [STATE_W-1:0] start_state_r;
  logic [SYM_W-1:0]   blank_symbol_r;
  logic [63:0]        final_mask_r;
  logic               wr_en;
  reg_idx_t           idx;

  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_t'(paddr[4:3]);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_count_r  <= STATE_COUNT_RST;
      start_state_r  <= START_STATE_RST;
      blank_symbol_r <= BLANK_RST;
      final_mask_r   <= FINAL_MASK_RST;
    end else if (wr_en) begin
      case (idx)
        REG_STATE_COUNT:  state_count_r  <= pwdata[COUNT_W-1:0];
        REG_START_STATE:  start_state_r  <= pwdata[STATE_W-1:0];
        REG_BLANK_SYMBOL: blank_symbol_r <= pwdata[SYM_W-1:0];
        REG_FINAL_MASK:   final_mask_r   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_STATE_COUNT:  prdata = PDATA_W'(state_count_r);
      REG_START_STATE:  prdata = PDATA_W'(start_state_r);
      REG_BLANK_SYMBOL: prdata = PDATA_W'(blank_symbol_r);
      REG_FINAL_MASK:   prdata = final_mask_r;
      default:          prdata = '0;
    endcase
  end

  assign state_count  = state_count_r;
  assign start_state  = start_state_r;
  assign blank_symbol = blank_symbol_r;
  assign final_mask   = final_mask_r;

endmodule

`default_nettype wire

[design/tmse_ctrl.sv]
// Controller state machine that sequences each item through the datapath.
`default_nettype none

module tmse_ctrl import tmse_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic [1:0] in_command,
  input  wire tmse_sts_t  sts,
  output logic            in_ready,
  output tmse_cmd_t       cmd
);

  ctrl_state_t state_r, state_nxt;
  logic        post_r, post_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      post_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      post_r  <= post_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    post_nxt  = post_r;
    cmd       = '0;
    cmd.post  = post_r;
    in_ready  = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take = 1'b1;
          case (op_t'(in_command))
            OP_DEFINE: state_nxt = S_DEF_RD;
            OP_START:  state_nxt = S_START;
            OP_APPEND: state_nxt = S_APPEND;
            OP_STEP: begin
              state_nxt = S_TAPE_RD;
              post_nxt  = 1'b0;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_DEF_RD: begin
        cmd.def_rd = 1'b1;
        state_nxt  = S_DEF_WR;
      end
      S_DEF_WR: begin
        cmd.def_wr = 1'b1;
        state_nxt  = S_TAPE_RD;
        post_nxt   = 1'b1;
      end
      S_START: begin
        cmd.start = 1'b1;
        state_nxt = S_TAPE_RD;
        post_nxt  = 1'b1;
      end
      S_APPEND: begin
        cmd.append = 1'b1;
        state_nxt  = S_TAPE_RD;
        post_nxt   = 1'b1;
      end
      S_TAPE_RD: begin
        cmd.tape_rd = 1'b1;
        state_nxt   = S_RULE_RD;
      end
      S_RULE_RD: begin
        cmd.rule_rd = 1'b1;
        state_nxt   = S_EVAL;
      end
      S_EVAL: begin
        if (!post_r && sts.rule_hit && !sts.grow_ovf) begin
          cmd.apply = 1'b1;
          post_nxt  = 1'b1;
          state_nxt = sts.grow_need ? S_GROW : S_TAPE_RD;
        end else if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_GROW: begin
        cmd.grow  = 1'b1;
        state_nxt = S_TAPE_RD;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

[design/tmse_dpath.sv]
// Datapath: rule table, tape store, machine registers and result register.
`default_nettype none

module tmse_dpath import tmse_pkg::*; #(
  parameter int MAX_STATES  = MAX_STATES_DEF,
  parameter int TAPE_DEPTH  = TAPE_DEPTH_DEF,
  parameter int SYMBOL_BITS = SYMBOL_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire tmse_cmd_t          cmd,
  output tmse_sts_t               sts,
  input  wire logic [STATE_W-1:0] in_from_state,
  input  wire logic [SYM_W-1:0]   in_match_symbol,
  input  wire logic [STATE_W-1:0] in_to_state,
  input  wire logic [SYM_W-1:0]   in_mark_symbol,
  input  wire logic [1:0]         in_move_code,
  input  wire logic [SYM_W-1:0]   in_tape_symbol,
  input  wire logic [COUNT_W-1:0] state_count,
  input  wire logic [STATE_W-1:0] start_state,
  input  wire logic [SYM_W-1:0]   blank_symbol,
  input  wire logic [63:0]        final_mask,
  input  wire logic               out_ready,
  output logic                    out_valid,
  output logic [2:0]              out_status,
  output logic [STATE_W-1:0]      out_current_state,
  output logic [SYM_W-1:0]        out_head_symbol,
  output logic [SYM_W-1:0]        out_written_symbol,
  output logic [1:0]              out_moved_direction,
  output logic                    out_halted_flag,
  output logic                    out_accepting_flag
);

  localparam int SB         = SYMBOL_BITS;
  localparam int SW         = $clog2(MAX_STATES);
  localparam int RULE_SLOTS = MAX_STATES << SYMBOL_BITS;
  localparam int AW         = SW + SB;
  localparam int RW         = 3 + STATE_W + SB;
  localparam int TW         = $clog2(TAPE_DEPTH);
  localparam int LW         = $clog2(TAPE_DEPTH + 1);
  localparam int CW         = 9;

  logic [RW-1:0] rule_mem [RULE_SLOTS];
  logic [SB-1:0] tape_mem [TAPE_DEPTH];
  logic [RW-1:0] rule_q;
  logic [SB-1:0] tape_q;

  logic [AW-1:0]      clr_cnt_r;
  logic [STATE_W-1:0] from_r, to_r;
  logic [SB-1:0]      rsym_r, wsym_r, tsym_r;
  logic [1:0]         mv_r;
  logic [STATE_W-1:0] state_r;
  logic [TW-1:0]      origin_r, head_r;
  logic [LW-1:0]      length_r;
  logic               appended_r;
  logic [2:0]         status_r;
  logic [SB-1:0]      written_r, head_sym_r;
  logic [1:0]         moved_r;

  logic               out_valid_r, out_halted_r, out_accepting_r;
  logic [2:0]         out_status_r;
  logic [STATE_W-1:0] out_state_r;
  logic [SYM_W-1:0]   out_head_r, out_written_r;
  logic [1:0]         out_moved_r;

  logic [SB-1:0]      blank;
  logic               from_ok, to_ok, start_ok, state_ok, rule_hit;
  logic [STATE_W-1:0] r_to;
  logic [SB-1:0]      r_wsym;
  logic [1:0]         r_mv;
  logic [LW-1:0]      head_plus, pos;
  logic               grow_need, full;
  logic [LW:0]        sum;
  logic [TW-1:0]      phys_addr, origin_dec;
  logic               tape_we;
  logic [TW-1:0]      tape_wa;
  logic [SB-1:0]      tape_wd;
  logic               rule_we;
  logic [AW-1:0]      rule_addr;
  logic [RW-1:0]      rule_wd;

  assign blank    = blank_symbol[SB-1:0];
  assign from_ok  = (COUNT_W'(from_r) < state_count) && (CW'(from_r) < CW'(MAX_STATES));
  assign to_ok    = (COUNT_W'(to_r) < state_count) && (CW'(to_r) < CW'(MAX_STATES));
  assign start_ok = (COUNT_W'(start_state) < state_count) &&
                    (CW'(start_state) < CW'(MAX_STATES));
  assign state_ok = CW'(state_r) < CW'(MAX_STATES);
  assign rule_hit = state_ok && rule_q[RW-1];

  assign r_to   = rule_q[RW-2 -: STATE_W];
  assign r_wsym = rule_q[SB+1:2];
  assign r_mv   = rule_q[1:0];

  assign head_plus = LW'(head_r) + LW'(1);
  assign full      = length_r >= LW'(TAPE_DEPTH);
  assign grow_need = ((r_mv == MV_LEFT) && (head_r == '0)) ||
                     ((r_mv == MV_RIGHT) && (head_plus >= length_r));

  assign pos        = cmd.append ? length_r : LW'(head_r);
  assign sum        = (LW+1)'(origin_r) + (LW+1)'(pos);
  assign phys_addr  = (sum >= (LW+1)'(TAPE_DEPTH)) ? TW'(sum - (LW+1)'(TAPE_DEPTH)) : TW'(sum);
  assign origin_dec = (origin_r == '0) ? TW'(TAPE_DEPTH - 1) : origin_r - TW'(1);

  assign sts.clr_last  = clr_cnt_r == AW'(RULE_SLOTS - 1);
  assign sts.rule_hit  = rule_hit;
  assign sts.grow_need = grow_need;
  assign sts.grow_ovf  = grow_need && full;
  assign sts.out_free  = !out_valid_r || out_ready;

  always_comb begin
    tape_we = 1'b0;
    tape_wa = phys_addr;
    tape_wd = blank;
    if (cmd.clr_step) begin
      tape_we = 1'b1;
      tape_wa = '0;
      tape_wd = BLANK_RST[SB-1:0];
    end else if (cmd.start) begin
      tape_we = start_ok;
      tape_wa = origin_r;
    end else if (cmd.append) begin
      tape_wd = tsym_r;
      if (!appended_r) begin
        tape_we = 1'b1;
        tape_wa = origin_r;
      end else begin
        tape_we = !full;
      end
    end else if (cmd.apply) begin
      tape_we = 1'b1;
      tape_wd = r_wsym;
    end else if (cmd.grow) begin
      tape_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (tape_we) begin
      tape_mem[tape_wa] <= tape_wd;
    end
    if (cmd.tape_rd) begin
      tape_q <= tape_mem[phys_addr];
    end
  end

  always_comb begin
    if (cmd.clr_step) begin
      rule_addr = clr_cnt_r;
    end else if (cmd.def_rd || cmd.def_wr) begin
      rule_addr = {SW'(from_r), rsym_r};
    end else begin
      rule_addr = {SW'(state_r), tape_q};
    end
    rule_we = cmd.clr_step || (cmd.def_wr && from_ok && to_ok && !rule_q[RW-1]);
    rule_wd = cmd.clr_step ? '0 : {1'b1, to_r, wsym_r, mv_r};
  end

  always_ff @(posedge clk) begin
    if (rule_we) begin
      rule_mem[rule_addr] <= rule_wd;
    end
    if (cmd.def_rd || cmd.rule_rd) begin
      rule_q <= rule_mem[rule_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      state_r     <= '0;
      origin_r    <= '0;
      length_r    <= LW'(1);
      head_r      <= '0;
      appended_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_step) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
      end
      if (cmd.start && start_ok) begin
        state_r    <= start_state;
        length_r   <= LW'(1);
        head_r     <= '0;
        appended_r <= 1'b0;
      end
      if (cmd.append) begin
        if (!appended_r) begin
          appended_r <= 1'b1;
        end else if (!full) begin
          length_r <= length_r + LW'(1);
        end
      end
      if (cmd.apply) begin
        state_r <= r_to;
        case (r_mv)
          MV_LEFT: begin
            if (head_r == '0) begin
              origin_r <= origin_dec;
              length_r <= length_r + LW'(1);
            end else begin
              head_r <= head_r - TW'(1);
            end
          end
          MV_RIGHT: begin
            if (grow_need) begin
              length_r <= length_r + LW'(1);
            end
            head_r <= head_r + TW'(1);
          end
          default: ;
        endcase
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      from_r <= in_from_state;
      rsym_r <= in_match_symbol[SB-1:0];
      to_r   <= in_to_state;
      wsym_r <= in_mark_symbol[SB-1:0];
      tsym_r <= in_tape_symbol[SB-1:0];
      mv_r   <= (in_move_code == MV_LEFT || in_move_code == MV_RIGHT) ? in_move_code : MV_STAY;
    end
    if (cmd.def_wr) begin
      status_r  <= !(from_ok && to_ok) ? ST_RANGE : (rule_q[RW-1] ? ST_DUP : ST_OK);
      written_r <= '0;
      moved_r   <= MV_STAY;
    end
    if (cmd.start) begin
      status_r  <= start_ok ? ST_OK : ST_RANGE;
      written_r <= '0;
      moved_r   <= MV_STAY;
    end
    if (cmd.append) begin
      status_r  <= (appended_r && full) ? ST_OVERFLOW : ST_OK;
      written_r <= '0;
      moved_r   <= MV_STAY;
    end
    if (cmd.apply) begin
      status_r  <= ST_OK;
      written_r <= r_wsym;
      moved_r   <= r_mv;
    end
    if (cmd.rule_rd) begin
      head_sym_r <= tape_q;
    end
    if (cmd.finish) begin
      if (cmd.post) begin
        out_status_r  <= status_r;
        out_written_r <= SYM_W'(written_r);
        out_moved_r   <= moved_r;
      end else begin
        out_status_r  <= rule_hit ? ST_OVERFLOW : ST_HALTED;
        out_written_r <= rule_hit ? '0 : SYM_W'(blank);
        out_moved_r   <= MV_STAY;
      end
      out_state_r     <= state_r;
      out_head_r      <= SYM_W'(head_sym_r);
      out_halted_r    <= !rule_hit;
      out_accepting_r <= !rule_hit && final_mask[state_r];
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_current_state   = out_state_r;
  assign out_head_symbol     = out_head_r;
  assign out_written_symbol  = out_written_r;
  assign out_moved_direction = out_moved_r;
  assign out_halted_flag     = out_halted_r;
  assign out_accepting_flag  = out_accepting_r;

endmodule

`default_nettype wire

[design/tape_machine_step_engine.sv]
// Top level of the single-tape Turing machine step engine.
//
// Items enter on the in_ channel (valid/ready) and each gives exactly one result
// on the out_ channel. Commands: define a rule, start a tape, append an input
// symbol, take one step. Registers sit on the APB-style port at byte 8*index.
// One item is worked at a time. The rule and tape memories are single-port
// with registered reads: each lookup reads the head cell, then the rule it
// selects. A define reads its rule slot, then writes it; start or append
// writes the tape; a taken step applies the rule and, when the tape grows,
// writes a blank cell, then looks up again. Every item ends with that
// lookup to report halted and head symbol.
// After reset the rule table is swept clear, one entry per cycle, over all
// MAX_STATES << SYMBOL_BITS entries (16384 by default); in_ready stays low
// meanwhile, while register writes are taken as usual. A result waits in the
// output register while the receiver stalls; the next item is accepted
// meanwhile, and its result is held back until the register frees.
`default_nettype none

`include "tape_machine_step_engine_macros.svh"

module tape_machine_step_engine import tmse_pkg::*; #(
  parameter int MAX_STATES  = MAX_STATES_DEF,
  parameter int TAPE_DEPTH  = TAPE_DEPTH_DEF,
  parameter int SYMBOL_BITS = SYMBOL_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         in_command,
  input  wire logic [STATE_W-1:0] in_from_state,
  input  wire logic [SYM_W-1:0]   in_match_symbol,
  input  wire logic [STATE_W-1:0] in_to_state,
  input  wire logic [SYM_W-1:0]   in_mark_symbol,
  input  wire logic [1:0]         in_move_code,
  input  wire logic [SYM_W-1:0]   in_tape_symbol,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [2:0]              out_status,
  output logic [STATE_W-1:0]      out_current_state,
  output logic [SYM_W-1:0]        out_head_symbol,
  output logic [SYM_W-1:0]        out_written_symbol,
  output logic [1:0]              out_moved_direction,
  output logic                    out_halted_flag,
  output logic                    out_accepting_flag,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready
);

  tmse_cmd_t          cmd;
  tmse_sts_t          sts;
  logic [COUNT_W-1:0] state_count;
  logic [STATE_W-1:0] start_state;
  logic [SYM_W-1:0]   blank_symbol;
  logic [63:0]        final_mask;

  tmse_regs u_regs (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .state_count  (state_count),
    .start_state  (start_state),
    .blank_symbol (blank_symbol),
    .final_mask   (final_mask)
  );

  tmse_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .sts        (sts),
    .in_ready   (in_ready),
    .cmd        (cmd)
  );

  tmse_dpath #(
    .MAX_STATES  (MAX_STATES),
    .TAPE_DEPTH  (TAPE_DEPTH),
    .SYMBOL_BITS (SYMBOL_BITS)
  ) u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_from_state       (in_from_state),
    .in_match_symbol     (in_match_symbol),
    .in_to_state         (in_to_state),
    .in_mark_symbol      (in_mark_symbol),
    .in_move_code        (in_move_code),
    .in_tape_symbol      (in_tape_symbol),
    .state_count         (state_count),
    .start_state         (start_state),
    .blank_symbol        (blank_symbol),
    .final_mask          (final_mask),
    .out_ready           (out_ready),
    .out_valid           (out_valid),
    .out_status          (out_status),
    .out_current_state   (out_current_state),
    .out_head_symbol     (out_head_symbol),
    .out_written_symbol  (out_written_symbol),
    .out_moved_direction (out_moved_direction),
    .out_halted_flag     (out_halted_flag),
    .out_accepting_flag  (out_accepting_flag)
  );

  `TMSE_ASSERT_NEXT(a_one_item_at_a_time, in_valid && in_ready, !in_ready)
  `TMSE_ASSERT_IMPLIES(a_finish_needs_free_output, cmd.finish, !out_valid || out_ready)
  `TMSE_ASSERT_IMPLIES(a_single_memory_update, 1'b1, $onehot0({cmd.clr_step, cmd.def_wr, cmd.start, cmd.append, cmd.apply, cmd.grow}))
  `TMSE_ASSERT_NEXT(a_finish_shows_result, cmd.finish, out_valid)

endmodule

`default_nettype wire

[test/tb_tape_machine_step_engine.sv]
// Self-checking regression for the tape machine step engine: random programs against a step predictor.
module tb_tape_machine_step_engine;
  import tmse_pkg::*;

  localparam int RULE_SLOTS = MAX_STATES_DEF << SYMBOL_BITS_DEF;
  localparam int TAPE_CELLS = TAPE_DEPTH_DEF;
  localparam int TAPE_AW = $clog2(TAPE_DEPTH_DEF);
  localparam int SETTLE_CYCLES = 10;
  localparam int RANDOM_ITEMS = 850;

  typedef struct packed {
    op_t                op;
    logic [STATE_W-1:0] from_state;
    logic [SYM_W-1:0]   match_symbol;
    logic [STATE_W-1:0] to_state;
    logic [SYM_W-1:0]   mark_symbol;
    logic [1:0]         move_code;
    logic [SYM_W-1:0]   tape_symbol;
  } tape_item_t;

  typedef struct packed {
    status_t            status;
    logic [STATE_W-1:0] mstate;
    logic [SYM_W-1:0]   head;
    logic [SYM_W-1:0]   written;
    move_t              moved;
    logic               halted;
    logic               accepting;
  } tape_result_t;

  class tape_scoreboard;
    bit                 rule_valid [RULE_SLOTS];
    bit [STATE_W-1:0]   rule_next [RULE_SLOTS];
    bit [SYM_W-1:0]     rule_write [RULE_SLOTS];
    move_t              rule_move [RULE_SLOTS];
    bit [SYM_W-1:0]     tape [TAPE_CELLS];
    bit [STATE_W-1:0]   mstate;
    bit [TAPE_AW-1:0]   origin;
    bit [TAPE_AW-1:0]   head;
    int                 tape_len;
    int                 appended;
    bit [COUNT_W-1:0]   state_count;
    bit [STATE_W-1:0]   start_state;
    bit [SYM_W-1:0]     blank;
    bit [63:0]          final_mask;
    bit                 halted_now;
    int                 errors;
    tape_result_t       expected_q [$];

    function new();
      state_count = STATE_COUNT_RST;
      start_state = START_STATE_RST;
      blank = BLANK_RST;
      final_mask = FINAL_MASK_RST;
      origin = '0;
      errors = 0;
      restart();
    endfunction

    function int eff_count();
      return (state_count < MAX_STATES_DEF) ? int'(state_count) : MAX_STATES_DEF;
    endfunction

    function bit [TAPE_AW-1:0] tape_addr(int pos);
      bit [TAPE_AW-1:0] p;
      p = pos[TAPE_AW-1:0];
      return origin + p;
    endfunction

    function bit [STATE_W+SYM_W-1:0] rule_slot();
      return {mstate, tape[tape_addr(int'(head))]};
    endfunction

    function void restart();
      mstate = start_state;
      tape_len = 1;
      head = '0;
      appended = 0;
      tape[tape_addr(0)] = blank;
    endfunction

    function void set_reg(reg_idx_t idx, logic [63:0] value);
      case (idx)
        REG_STATE_COUNT:  state_count = value[COUNT_W-1:0];
        REG_START_STATE:  start_state = value[STATE_W-1:0];
        REG_BLANK_SYMBOL: blank = value[SYM_W-1:0];
        REG_FINAL_MASK:   final_mask = value;
        default: ;
      endcase
    endfunction

    function void note_item(tape_item_t it);
      tape_result_t r;
      bit [STATE_W+SYM_W-1:0] s;
      move_t mv;
      bit grow;
      r = '0;
      r.status = ST_OK;
      r.moved = MV_STAY;
      case (it.op)
        OP_DEFINE: begin
          mv = (it.move_code == 2'd3) ? MV_STAY : move_t'(it.move_code);
          if (it.from_state >= eff_count() || it.to_state >= eff_count()) begin
            r.status = ST_RANGE;
          end else begin
            s = {it.from_state, it.match_symbol};
            if (rule_valid[s]) begin
              r.status = ST_DUP;
            end else begin
              rule_valid[s] = 1'b1;
              rule_next[s] = it.to_state;
              rule_write[s] = it.mark_symbol;
              rule_move[s] = mv;
            end
          end
        end
        OP_START: begin
          if (start_state >= eff_count()) r.status = ST_RANGE;
          else restart();
        end
        OP_APPEND: begin
          if (appended == 0) begin
            tape[tape_addr(0)] = it.tape_symbol;
            appended = 1;
          end else if (tape_len >= TAPE_CELLS) begin
            r.status = ST_OVERFLOW;
          end else begin
            tape[tape_addr(tape_len)] = it.tape_symbol;
            tape_len++;
            appended++;
          end
        end
        OP_STEP: begin
          s = rule_slot();
          if (!rule_valid[s]) begin
            r.status = ST_HALTED;
            r.written = blank;
          end else begin
            mv = rule_move[s];
            grow = (mv == MV_LEFT && head == 0) ||
                   (mv == MV_RIGHT && int'(head) + 1 >= tape_len);
            if (grow && tape_len >= TAPE_CELLS) begin
              r.status = ST_OVERFLOW;
            end else begin
              mstate = rule_next[s];
              tape[tape_addr(int'(head))] = rule_write[s];
              if (mv == MV_LEFT) begin
                if (head == 0) begin
                  origin = origin - 1'b1;
                  tape[origin] = blank;
                  tape_len++;
                end else begin
                  head = head - 1'b1;
                end
              end else if (mv == MV_RIGHT) begin
                if (grow) begin
                  tape[tape_addr(tape_len)] = blank;
                  tape_len++;
                end
                head = head + 1'b1;
              end
              r.written = rule_write[s];
              r.moved = mv;
            end
          end
        end
      endcase
      s = rule_slot();
      r.halted = !rule_valid[s];
      r.accepting = r.halted && final_mask[mstate];
      r.mstate = mstate;
      r.head = tape[tape_addr(int'(head))];
      halted_now = r.halted;
      expected_q.push_back(r);
    endfunction

    function void compare(string field, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", field, want, got);
        errors++;
      end
    endfunction

    function void check(tape_result_t got);
      tape_result_t want;
      if (expected_q.size() == 0) begin
        $error("result with none pending: status %0h state %0h", got.status, got.mstate);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      compare("status", 64'(want.status), 64'(got.status));
      compare("current_state", 64'(want.mstate), 64'(got.mstate));
      compare("head_symbol", 64'(want.head), 64'(got.head));
      compare("written_symbol", 64'(want.written), 64'(got.written));
      compare("moved_direction", 64'(want.moved), 64'(got.moved));
      compare("halted_flag", 64'(want.halted), 64'(got.halted));
      compare("accepting_flag", 64'(want.accepting), 64'(got.accepting));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_command = '0;
  logic [STATE_W-1:0] in_from_state = '0;
  logic [SYM_W-1:0] in_match_symbol = '0;
  logic [STATE_W-1:0] in_to_state = '0;
  logic [SYM_W-1:0] in_mark_symbol = '0;
  logic [1:0] in_move_code = '0;
  logic [SYM_W-1:0] in_tape_symbol = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] out_status;
  logic [STATE_W-1:0] out_current_state;
  logic [SYM_W-1:0] out_head_symbol;
  logic [SYM_W-1:0] out_written_symbol;
  logic [1:0] out_moved_direction;
  logic out_halted_flag;
  logic out_accepting_flag;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  tape_scoreboard store = new();
  bit quiet = 1'b0;
  logic hold_off = 1'b0;
  int accepted_items = 0;
  int stall_left = 0;
  tape_result_t seen;

  tape_machine_step_engine u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_command          (in_command),
    .in_from_state       (in_from_state),
    .in_match_symbol     (in_match_symbol),
    .in_to_state         (in_to_state),
    .in_mark_symbol      (in_mark_symbol),
    .in_move_code        (in_move_code),
    .in_tape_symbol      (in_tape_symbol),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_current_state   (out_current_state),
    .out_head_symbol     (out_head_symbol),
    .out_written_symbol  (out_written_symbol),
    .out_moved_direction (out_moved_direction),
    .out_halted_flag     (out_halted_flag),
    .out_accepting_flag  (out_accepting_flag),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  always #6 clk = ~clk;

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic tape_item_t noise_item();
    tape_item_t it;
    it.op = op_t'($urandom_range(0, 3));
    it.from_state = STATE_W'($urandom_range(0, 63));
    it.match_symbol = SYM_W'($urandom_range(0, 255));
    it.to_state = STATE_W'($urandom_range(0, 63));
    it.mark_symbol = SYM_W'($urandom_range(0, 255));
    it.move_code = 2'($urandom_range(0, 3));
    it.tape_symbol = SYM_W'($urandom_range(0, 255));
    return it;
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      seen.status = status_t'(out_status);
      seen.mstate = out_current_state;
      seen.head = out_head_symbol;
      seen.written = out_written_symbol;
      seen.moved = move_t'(out_moved_direction);
      seen.halted = out_halted_flag;
      seen.accepting = out_accepting_flag;
      store.check(seen);
    end
    if (stall_left > 0) stall_left--;
    else stall_left = pick_gap();
    out_ready <= !hold_off && stall_left == 0;
  end

  // hold the result side off long enough for the input side to back up
  initial begin
    wait (accepted_items >= 100);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (300) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    #15_000_000;
    $display("tape_machine_step_engine regression: fail");
    $finish;
  end

  task automatic send_item(tape_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= it.op;
    in_from_state <= it.from_state;
    in_match_symbol <= it.match_symbol;
    in_to_state <= it.to_state;
    in_mark_symbol <= it.mark_symbol;
    in_move_code <= it.move_code;
    in_tape_symbol <= it.tape_symbol;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    store.note_item(it);
    accepted_items++;
  endtask

  task automatic define_rule(logic [STATE_W-1:0] from, logic [SYM_W-1:0] rsym,
                             logic [STATE_W-1:0] to, logic [SYM_W-1:0] wsym,
                             logic [1:0] mv);
    tape_item_t it;
    it = noise_item();
    it.op = OP_DEFINE;
    it.from_state = from;
    it.match_symbol = rsym;
    it.to_state = to;
    it.mark_symbol = wsym;
    it.move_code = mv;
    send_item(it);
  endtask

  task automatic do_cmd(op_t op, logic [SYM_W-1:0] sym);
    tape_item_t it;
    it = noise_item();
    it.op = op;
    it.tape_symbol = sym;
    send_item(it);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [63:0] value);
    in_valid <= 1'b0;
    while (store.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    store.set_reg(idx, value);
    @(posedge clk);
  endtask

  task automatic configure(logic [COUNT_W-1:0] count, logic [STATE_W-1:0] first,
                           logic [SYM_W-1:0] blank, logic [63:0] mask);
    write_reg(REG_STATE_COUNT, 64'(count));
    write_reg(REG_START_STATE, 64'(first));
    write_reg(REG_BLANK_SYMBOL, 64'(blank));
    write_reg(REG_FINAL_MASK, mask);
  endtask

  task automatic random_config();
    logic [COUNT_W-1:0] count;
    logic [STATE_W-1:0] first;
    logic [SYM_W-1:0] blank;
    logic [63:0] mask;
    int eff;
    case ($urandom_range(0, 5))
      0: count = 7'd1;
      1: count = 7'd64;
      2: count = 7'd127;
      3: count = 7'd0;
      default: count = COUNT_W'($urandom_range(2, 63));
    endcase
    eff = (count < MAX_STATES_DEF) ? int'(count) : MAX_STATES_DEF;
    if (eff == 0 || $urandom_range(0, 4) == 0) first = STATE_W'($urandom_range(0, 63));
    else first = STATE_W'($urandom_range(0, eff - 1));
    case ($urandom_range(0, 4))
      0: blank = 8'h00;
      1: blank = 8'hFF;
      2: blank = BLANK_RST;
      default: blank = SYM_W'($urandom_range(0, 255));
    endcase
    case ($urandom_range(0, 3))
      0: mask = '0;
      1: mask = '1;
      default: mask = {$urandom, $urandom};
    endcase
    configure(count, first, blank, mask);
  endtask

  // define a small machine over a few symbols, load a tape and run it
  task automatic run_program();
    logic [SYM_W-1:0] syms [4];
    logic [STATE_W-1:0] states [4];
    int nsym;
    int nst;
    int eff;
    int nsteps;
    eff = store.eff_count();
    nsym = $urandom_range(2, 4);
    nst = $urandom_range(1, 4);
    syms[0] = store.blank;
    for (int i = 1; i < 4; i++) syms[i] = SYM_W'($urandom_range(0, 255));
    states[0] = store.start_state;
    for (int i = 1; i < 4; i++) begin
      states[i] = (eff == 0) ? '0 : STATE_W'($urandom_range(0, eff - 1));
    end
    for (int i = 0; i < nst; i++) begin
      for (int j = 0; j < nsym; j++) begin
        if ($urandom_range(0, 9) < 8)
          define_rule(states[i], syms[j], states[$urandom_range(0, nst - 1)],
                      syms[$urandom_range(0, nsym - 1)], 2'($urandom_range(0, 3)));
        if ($urandom_range(0, 19) == 0) send_item(noise_item());
      end
    end
    do_cmd(OP_START, SYM_W'($urandom_range(0, 255)));
    repeat ($urandom_range(0, 6)) begin
      if ($urandom_range(0, 9) == 0) do_cmd(OP_APPEND, SYM_W'($urandom_range(0, 255)));
      else do_cmd(OP_APPEND, syms[$urandom_range(0, nsym - 1)]);
    end
    nsteps = $urandom_range(4, 40);
    for (int k = 0; k < nsteps; k++) begin
      do_cmd(OP_STEP, SYM_W'($urandom_range(0, 255)));
      if (store.halted_now && $urandom_range(0, 3) == 0) break;
      if ($urandom_range(0, 29) == 0) send_item(noise_item());
    end
  endtask

  initial begin
    int target;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    configure(7'd4, 6'd1, BLANK_RST, 64'h8000_0000_0000_0008);
    do_cmd(OP_STEP, 8'h00);
    do_cmd(OP_APPEND, 8'hFF);
    do_cmd(OP_APPEND, 8'h00);
    define_rule(6'd1, 8'hFF, 6'd2, 8'h00, MV_RIGHT);
    define_rule(6'd1, 8'hFF, 6'd3, 8'h11, MV_LEFT);
    define_rule(6'd4, 8'h00, 6'd0, 8'h00, MV_RIGHT);
    define_rule(6'd0, 8'h00, 6'd63, 8'h00, MV_RIGHT);
    define_rule(6'd2, 8'h00, 6'd3, 8'hFF, 2'd3);
    define_rule(6'd3, 8'hFF, 6'd1, 8'hAA, MV_LEFT);
    define_rule(6'd1, 8'h00, 6'd0, BLANK_RST, MV_LEFT);
    define_rule(6'd0, BLANK_RST, 6'd3, 8'h00, MV_RIGHT);
    do_cmd(OP_START, 8'h00);
    do_cmd(OP_APPEND, 8'hFF);
    do_cmd(OP_APPEND, 8'h00);
    repeat (7) do_cmd(OP_STEP, SYM_W'($urandom_range(0, 255)));
    write_reg(REG_START_STATE, 64'd5);
    do_cmd(OP_START, 8'h00);
    do_cmd(OP_STEP, 8'hFF);

    target = accepted_items + RANDOM_ITEMS;
    while (accepted_items < target) begin
      random_config();
      quiet = ($urandom_range(0, 3) == 0);
      repeat (2) run_program();
    end

    in_valid <= 1'b0;
    while (store.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (store.errors == 0) begin
      $display("tape_machine_step_engine regression: pass");
    end else begin
      $display("tape_machine_step_engine regression: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+design
design/tmse_pkg.sv
design/tmse_regs.sv
design/tmse_ctrl.sv
design/tmse_dpath.sv
design/tape_machine_step_engine.sv
test/tb_tape_machine_step_engine.sv
